/* hw/rtl/crat_pkg.sv */
// Shared types and constants for the capture request acknowledgment tracker.
package crat_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_WAIT     = 2'd1,
        MODE_AUTO     = 2'd2,
        MODE_AUTO_ACK = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_MANUAL_REQ = 3'd1,
        OP_ACK_OK     = 3'd2,
        OP_ACK_ERR    = 3'd3,
        OP_AUTO_START = 3'd4,
        OP_AUTO_STOP  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        REASON_OK       = 3'd0,
        REASON_REMOTE   = 3'd1,
        REASON_TIMEOUT  = 3'd2,
        REASON_MISMATCH = 3'd3,
        REASON_TX_FAIL  = 3'd4
    } reason_t;

    localparam int unsigned CFG_BITS = 16;
    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACK_TIMEOUT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_INTERVAL = 2'd1;

    localparam logic [CFG_BITS-1:0] ACK_TIMEOUT_RESET  = 16'd2000;
    localparam logic [CFG_BITS-1:0] MIN_INTERVAL_RESET = 16'd50;

endpackage

/* hw/rtl/capture_request_ack_tracker.sv */
// Capture request tracker: request ids, ack matching, timeout and auto trigger.
//
//  channel  | valid / ready          | payload
//  ---------+------------------------+---------------------------------------------
//  s_       | s_valid / s_ready      | s_opcode, s_ack_id, s_interval, s_tx_ok
//  m_       | m_valid / m_ready      | m_accepted .. m_last_done_ok
//  cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every request yields one result, registered when it is accepted and presented in the next cycle.
// One request per cycle while s_ready is high: the state update is a single pass of compares and counters.
// s_ready is low only while a result is held and m_ready is low.
// cfg_ready is always high; reset loads the default timeout and minimum interval.
// Reset (aresetn low, synchronous) returns to idle with the next request id at 1.
module capture_request_ack_tracker
    import crat_pkg::*;
#(
    parameter int unsigned ID_BITS       = 32,
    parameter int unsigned INTERVAL_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_opcode,
    input  logic [ID_BITS-1:0]        s_ack_id,
    input  logic [INTERVAL_BITS-1:0]  s_interval,
    input  logic                      s_tx_ok,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_accepted,
    output logic                      m_send_cmd,
    output logic [ID_BITS-1:0]        m_send_id,
    output logic                      m_notice_valid,
    output logic                      m_notice_ok,
    output logic [ID_BITS-1:0]        m_notice_id,
    output logic [2:0]                m_notice_reason,
    output logic [1:0]                m_mode_state,
    output logic                      m_auto_on,
    output logic [ID_BITS-1:0]        m_last_done_id,
    output logic                      m_last_done_ok
);

    localparam int unsigned CMP_BITS = (INTERVAL_BITS > CFG_BITS) ? INTERVAL_BITS : CFG_BITS;
    localparam logic [INTERVAL_BITS-1:0] IV_MAX = {INTERVAL_BITS{1'b1}};

    // configuration
    logic [CFG_BITS-1:0]      ack_timeout_reg;
    logic [CFG_BITS-1:0]      min_interval_reg;

    // tracker state
    mode_t                    mode_reg, mode_next;
    logic [ID_BITS-1:0]       next_id_reg, next_id_next;
    logic [ID_BITS-1:0]       pending_id_reg, pending_id_next;
    logic [CFG_BITS-1:0]      wait_elapsed_reg, wait_elapsed_next;
    logic [INTERVAL_BITS-1:0] auto_elapsed_reg, auto_elapsed_next;
    logic [INTERVAL_BITS-1:0] auto_period_reg, auto_period_next;
    logic                     auto_enabled_reg, auto_enabled_next;
    logic [ID_BITS-1:0]       done_id_reg, done_id_next;
    logic                     done_ok_reg, done_ok_next;

    // result register
    logic                     m_valid_reg;
    logic                     accepted_reg, accepted_next;
    logic                     send_reg, send_next;
    logic [ID_BITS-1:0]       send_id_reg, send_id_next;
    logic                     notice_valid_reg, notice_valid_next;
    logic                     notice_ok_reg, notice_ok_next;
    logic [ID_BITS-1:0]       notice_id_reg, notice_id_next;
    reason_t                  notice_reason_reg, notice_reason_next;

    logic                     s_fire;
    logic                     waiting;
    logic [INTERVAL_BITS-1:0] auto_elapsed_inc;
    logic [CMP_BITS-1:0]      interval_ext;
    logic [CMP_BITS-1:0]      min_interval_ext;
    logic [CMP_BITS-1:0]      interval_clamped;
    logic                     do_complete;
    logic [ID_BITS-1:0]       cpl_id;
    logic                     cpl_ok;
    reason_t                  cpl_reason;
    logic                     do_start;
    logic                     start_auto;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign waiting   = (mode_reg == MODE_WAIT) || (mode_reg == MODE_AUTO_ACK);

    assign auto_elapsed_inc = (auto_elapsed_reg == IV_MAX) ? auto_elapsed_reg
                                                            : auto_elapsed_reg + 1'b1;
    assign interval_ext     = CMP_BITS'(s_interval);
    assign min_interval_ext = CMP_BITS'(min_interval_reg);
    assign interval_clamped = (interval_ext < min_interval_ext) ? min_interval_ext
                                                                : interval_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg  <= ACK_TIMEOUT_RESET;
            min_interval_reg <= MIN_INTERVAL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_data;
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            next_id_reg      <= ID_BITS'(1);
            pending_id_reg   <= '0;
            wait_elapsed_reg <= '0;
            auto_elapsed_reg <= '0;
            auto_period_reg  <= '0;
            auto_enabled_reg <= 1'b0;
            done_id_reg      <= '0;
            done_ok_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_fire) begin
                mode_reg         <= mode_next;
                next_id_reg      <= next_id_next;
                pending_id_reg   <= pending_id_next;
                wait_elapsed_reg <= wait_elapsed_next;
                auto_elapsed_reg <= auto_elapsed_next;
                auto_period_reg  <= auto_period_next;
                auto_enabled_reg <= auto_enabled_next;
                done_id_reg      <= done_id_next;
                done_ok_reg      <= done_ok_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg      <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            accepted_reg      <= accepted_next;
            send_reg          <= send_next;
            send_id_reg       <= send_id_next;
            notice_valid_reg  <= notice_valid_next;
            notice_ok_reg     <= notice_ok_next;
            notice_id_reg     <= notice_id_next;
            notice_reason_reg <= notice_reason_next;
        end
    end

    // decode: which completion or send this request causes
    always_comb begin
        do_complete = 1'b0;
        cpl_id      = s_ack_id;
        cpl_ok      = 1'b0;
        cpl_reason  = REASON_OK;
        do_start    = 1'b0;
        start_auto  = 1'b0;
        unique case (s_opcode)
            OP_TICK: begin
                if (waiting && (wait_elapsed_reg >= ack_timeout_reg)) begin
                    do_complete = 1'b1;
                    cpl_id      = pending_id_reg;
                    cpl_reason  = REASON_TIMEOUT;
                end else if (mode_reg == MODE_AUTO && auto_enabled_reg
                             && (auto_elapsed_inc >= auto_period_reg)) begin
                    do_start   = s_tx_ok;
                    start_auto = 1'b1;
                end
            end
            OP_MANUAL_REQ: begin
                do_start = !waiting && s_tx_ok;
            end
            OP_ACK_OK: begin
                do_complete = 1'b1;
                cpl_ok      = 1'b1;
            end
            OP_ACK_ERR: begin
                do_complete = 1'b1;
                cpl_reason  = REASON_REMOTE;
            end
            default: ;
        endcase
    end

    // next state and result
    always_comb begin
        mode_next          = mode_reg;
        next_id_next       = next_id_reg;
        pending_id_next    = pending_id_reg;
        wait_elapsed_next  = wait_elapsed_reg;
        auto_elapsed_next  = auto_elapsed_reg;
        auto_period_next   = auto_period_reg;
        auto_enabled_next  = auto_enabled_reg;
        done_id_next       = done_id_reg;
        done_ok_next       = done_ok_reg;
        accepted_next      = 1'b1;
        send_next          = 1'b0;
        send_id_next       = '0;
        notice_valid_next  = 1'b0;
        notice_ok_next     = 1'b0;
        notice_id_next     = '0;
        notice_reason_next = REASON_OK;

        if (do_complete) begin
            notice_valid_next = 1'b1;
            notice_id_next    = cpl_id;
            if (waiting && (cpl_id != pending_id_reg)) begin
                notice_reason_next = REASON_MISMATCH;
            end else begin
                notice_ok_next     = cpl_ok;
                notice_reason_next = cpl_reason;
                done_id_next       = cpl_id;
                done_ok_next       = cpl_ok;
                pending_id_next    = '0;
                wait_elapsed_next  = '0;
                if (auto_enabled_reg) begin
                    mode_next         = MODE_AUTO;
                    auto_elapsed_next = '0;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
        end else if (do_start) begin
            send_next         = 1'b1;
            send_id_next      = next_id_reg;
            pending_id_next   = next_id_reg;
            next_id_next      = next_id_reg + 1'b1;
            wait_elapsed_next = '0;
            mode_next         = (start_auto || auto_enabled_reg) ? MODE_AUTO_ACK : MODE_WAIT;
            if (start_auto) begin
                auto_elapsed_next = '0;
            end
        end else begin
            unique case (s_opcode)
                OP_TICK: begin
                    if (waiting) begin
                        wait_elapsed_next = wait_elapsed_reg + 1'b1;
                    end else if (mode_reg == MODE_AUTO && auto_enabled_reg) begin
                        if (start_auto) begin
                            // auto trigger with the link busy: drop it as failed
                            auto_elapsed_next  = '0;
                            done_id_next       = next_id_reg;
                            done_ok_next       = 1'b0;
                            notice_valid_next  = 1'b1;
                            notice_id_next     = next_id_reg;
                            notice_reason_next = REASON_TX_FAIL;
                        end else begin
                            auto_elapsed_next = auto_elapsed_inc;
                        end
                    end
                end
                OP_MANUAL_REQ: begin
                    accepted_next = 1'b0;
                end
                OP_AUTO_START: begin
                    if (waiting) begin
                        accepted_next = 1'b0;
                    end else begin
                        auto_enabled_next = 1'b1;
                        auto_period_next  = interval_clamped[INTERVAL_BITS-1:0];
                        // load the period so the next tick triggers
                        auto_elapsed_next = interval_clamped[INTERVAL_BITS-1:0];
                        mode_next         = MODE_AUTO;
                    end
                end
                OP_AUTO_STOP: begin
                    auto_enabled_next = 1'b0;
                    auto_period_next  = '0;
                    if (mode_reg == MODE_AUTO) begin
                        mode_next = MODE_IDLE;
                    end else if (mode_reg == MODE_AUTO_ACK) begin
                        mode_next = MODE_WAIT;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = accepted_reg;
    assign m_send_cmd      = send_reg;
    assign m_send_id       = send_id_reg;
    assign m_notice_valid  = notice_valid_reg;
    assign m_notice_ok     = notice_ok_reg;
    assign m_notice_id     = notice_id_reg;
    assign m_notice_reason = notice_reason_reg;
    assign m_mode_state    = mode_reg;
    assign m_auto_on       = auto_enabled_reg;
    assign m_last_done_id  = done_id_reg;
    assign m_last_done_ok  = done_ok_reg;

    // auto modes and the enable move together
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg[1] == auto_enabled_reg)
        else $error("auto mode and auto enable disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("accepted request produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && send_reg |-> accepted_reg && !notice_valid_reg)
        else $error("command sent together with a refusal or notice");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && do_start |=> (pending_id_reg == send_id_reg)
                               && (next_id_reg == send_id_reg + 1'b1))
        else $error("request id bookkeeping broken after send");

endmodule
